// File: sv/compact_support_correlation_defines.svh
// assertion macros shared by the checker
`ifndef COMPACT_SUPPORT_CORRELATION_DEFINES_SVH
`define COMPACT_SUPPORT_CORRELATION_DEFINES_SVH

// implication in the same cycle
`define CSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csc assertion failed");

// implication in the next cycle
`define CSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csc assertion failed");

`endif

// File: sv/csc_pkg.sv
package csc_pkg;

  // internal fixed point: Q2.30
  localparam int          WF         = 30;
  localparam logic [30:0] ONE_W      = 31'h4000_0000;
  localparam logic [31:0] PI_W       = 32'd3373259426;
  localparam logic [31:0] HALF_PI_W  = 32'd1686629713;
  localparam logic [28:0] INV_PI_W   = 29'd341782637;
  localparam logic [29:0] CORDIC_K_W = 30'd652032874;
  localparam int          MAX_ITER   = 24;

  // register indexes
  localparam logic [1:0] REG_KERNEL_SELECT  = 2'd0;
  localparam logic [1:0] REG_SHAPE_EXPONENT = 2'd1;
  localparam logic [1:0] REG_OUTER_EXPONENT = 2'd2;

  // datapath operations
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MARK_OOS,
    OP_BOH_Z,
    OP_CORDIC,
    OP_BOH_M1,
    OP_BOH_M2,
    OP_POW_INIT,
    OP_NORM,
    OP_LOG,
    OP_LOG_MUL,
    OP_EXP,
    OP_EXP_FIN,
    OP_ACC,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic second;
  } csc_cmd_t;

  typedef struct packed {
    logic out_range;
    logic kernel_sel;
    logic pow_trivial;
    logic norm_done;
    logic last_step;
    logic last_dim;
    logic out_free;
  } csc_status_t;

  // cordic arctangent table, atan(2^-i) in Q30
  function automatic logic [29:0] atan_w(input logic [4:0] idx);
    logic [29:0] val;
    case (idx)
      5'd0:    val = 30'd843314856;
      5'd1:    val = 30'd497837829;
      5'd2:    val = 30'd263043836;
      5'd3:    val = 30'd133525158;
      5'd4:    val = 30'd67021686;
      5'd5:    val = 30'd33543515;
      5'd6:    val = 30'd16775850;
      5'd7:    val = 30'd8388437;
      5'd8:    val = 30'd4194282;
      5'd9:    val = 30'd2097149;
      5'd10:   val = 30'd1048575;
      5'd11:   val = 30'd524287;
      5'd12:   val = 30'd262143;
      5'd13:   val = 30'd131071;
      5'd14:   val = 30'd65535;
      5'd15:   val = 30'd32767;
      5'd16:   val = 30'd16383;
      5'd17:   val = 30'd8191;
      5'd18:   val = 30'd4095;
      5'd19:   val = 30'd2047;
      5'd20:   val = 30'd1023;
      5'd21:   val = 30'd511;
      5'd22:   val = 30'd255;
      5'd23:   val = 30'd127;
      default: val = '0;
    endcase
    return val;
  endfunction

  // floor square root, elaboration use only
  function automatic logic [63:0] isqrt(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = val;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // successive roots 2^(-2^-(i+1)), each the floor root of the one before
  function automatic logic [MAX_ITER*31-1:0] build_roots();
    logic [MAX_ITER*31-1:0] tbl;
    logic [63:0]            s;
    tbl = '0;
    s   = 64'(ONE_W) >> 1;
    for (int i = 0; i < MAX_ITER; i++) begin
      s = isqrt(s << WF);
      tbl[i*31 +: 31] = s[30:0];
    end
    return tbl;
  endfunction

  localparam logic [MAX_ITER*31-1:0] ROOT_TABLE = build_roots();

  function automatic logic [30:0] root_w(input logic [4:0] idx);
    return ROOT_TABLE[idx*31 +: 31];
  endfunction

endpackage

// File: sv/csc_ctrl.sv
module csc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output csc_pkg::csc_cmd_t    cmd_o,
  input  csc_pkg::csc_status_t status_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_LO   = 4'd1;
  localparam logic [3:0] S_MUL_HI   = 4'd2;
  localparam logic [3:0] S_DISPATCH = 4'd3;
  localparam logic [3:0] S_CORDIC   = 4'd4;
  localparam logic [3:0] S_BOH_M1   = 4'd5;
  localparam logic [3:0] S_BOH_M2   = 4'd6;
  localparam logic [3:0] S_PW_NORM  = 4'd7;
  localparam logic [3:0] S_PW_LOG   = 4'd8;
  localparam logic [3:0] S_PW_LMUL  = 4'd9;
  localparam logic [3:0] S_PW_EXP   = 4'd10;
  localparam logic [3:0] S_PW_FIN   = 4'd11;
  localparam logic [3:0] S_PW_NEXT  = 4'd12;
  localparam logic [3:0] S_ACC      = 4'd13;
  localparam logic [3:0] S_FINISH   = 4'd14;

  logic [3:0] state_q, state_d;
  logic       pass_q, pass_d;

  // state and pass registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  // sequencing of the shared datapath
  always_comb begin
    state_d       = state_q;
    pass_d        = pass_q;
    cmd_o.op      = csc_pkg::OP_IDLE;
    cmd_o.second  = 1'b0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = csc_pkg::OP_LOAD;
          state_d  = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd_o.op = csc_pkg::OP_MUL_LO;
        state_d  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.op = csc_pkg::OP_MUL_HI;
        state_d  = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (status_i.out_range) begin
          cmd_o.op = csc_pkg::OP_MARK_OOS;
          state_d  = S_FINISH;
        end else if (status_i.kernel_sel) begin
          cmd_o.op = csc_pkg::OP_POW_INIT;
          pass_d   = 1'b0;
          state_d  = S_PW_NORM;
        end else begin
          cmd_o.op = csc_pkg::OP_BOH_Z;
          state_d  = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cmd_o.op = csc_pkg::OP_CORDIC;
        if (status_i.last_step) begin
          state_d = S_BOH_M1;
        end
      end
      S_BOH_M1: begin
        cmd_o.op = csc_pkg::OP_BOH_M1;
        state_d  = S_BOH_M2;
      end
      S_BOH_M2: begin
        cmd_o.op = csc_pkg::OP_BOH_M2;
        state_d  = S_ACC;
      end
      S_PW_NORM: begin
        if (status_i.pow_trivial) begin
          state_d = S_PW_FIN;
        end else if (!status_i.norm_done) begin
          cmd_o.op = csc_pkg::OP_NORM;
        end else begin
          cmd_o.op = csc_pkg::OP_LOG;
          state_d  = S_PW_LOG;
        end
      end
      S_PW_LOG: begin
        cmd_o.op = csc_pkg::OP_LOG;
        if (status_i.last_step) begin
          state_d = S_PW_LMUL;
        end
      end
      S_PW_LMUL: begin
        cmd_o.op = csc_pkg::OP_LOG_MUL;
        state_d  = S_PW_EXP;
      end
      S_PW_EXP: begin
        cmd_o.op = csc_pkg::OP_EXP;
        if (status_i.last_step) begin
          state_d = S_PW_FIN;
        end
      end
      S_PW_FIN: begin
        cmd_o.op = csc_pkg::OP_EXP_FIN;
        state_d  = pass_q ? S_ACC : S_PW_NEXT;
      end
      S_PW_NEXT: begin
        cmd_o.op     = csc_pkg::OP_POW_INIT;
        cmd_o.second = 1'b1;
        pass_d       = 1'b1;
        state_d      = S_PW_NORM;
      end
      S_ACC: begin
        cmd_o.op = csc_pkg::OP_ACC;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (!status_i.last_dim) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.op = csc_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/csc_dp.sv
module csc_dp #(
  parameter int FRAC_BITS  = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  csc_pkg::csc_cmd_t    cmd_i,
  output csc_pkg::csc_status_t status_o,
  input  logic signed [31:0]   coord_first_i,
  input  logic signed [31:0]   coord_second_i,
  input  logic [31:0]          inv_cutoff_i,
  input  logic                 last_dim_i,
  input  logic                 kernel_select_i,
  input  logic [15:0]          shape_exponent_i,
  input  logic [15:0]          outer_exponent_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [FRAC_BITS:0]   correlation_o,
  output logic                 in_support_o
);

  localparam int               CW      = $clog2(ITERATIONS);
  localparam int               RW      = FRAC_BITS + 1;
  localparam logic [RW-1:0]    ONE_OUT = RW'(1) << FRAC_BITS;
  localparam logic [CW-1:0]    LAST_IT = CW'(ITERATIONS - 1);
  localparam logic [4:0]       TOP_BIT = 5'd29;

  // item and scaled distance
  logic [31:0]        diff_q, diff_d;
  logic [31:0]        inv_q, inv_d;
  logic               last_q, last_d;
  logic [63:0]        prod_q, prod_d;
  // cordic
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d, t1_q, t1_d;
  // log / exp unit
  logic [30:0]        m_q, m_d;
  logic [4:0]         n_q, n_d;
  logic [29:0]        f_q, f_d;
  logic [38:0]        u_q, u_d;
  logic [30:0]        v_q, v_d;
  logic [30:0]        pval_q, pval_d;
  logic [15:0]        yexp_q, yexp_d;
  logic               base_zero_q, base_zero_d, exp_zero_q, exp_zero_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  // kernel value and running product
  logic signed [34:0] k_q, k_d;
  logic [RW-1:0]      rp_q, rp_d;
  logic               oos_q, oos_d;
  logic               out_valid_q, out_valid_d;
  logic [RW-1:0]      out_corr_q, out_corr_d;
  logic               out_sup_q, out_sup_d;

  // combinational terms
  logic signed [32:0] sub;
  logic [32:0]        sub_neg;
  logic [31:0]        diff_in;
  logic [15:0]        half_sel;
  logic [47:0]        pp;
  logic [30:0]        r30;
  logic [62:0]        zp;
  logic signed [33:0] ysh, xsh, at;
  logic [30:0]        om;
  logic signed [31:0] om_s;
  logic signed [34:0] negy;
  logic signed [66:0] m1p;
  logic signed [29:0] invpi_s;
  logic signed [63:0] m2p;
  logic [30:0]        base;
  logic [15:0]        yexp;
  logic [61:0]        msq;
  logic [34:0]        logv;
  logic [50:0]        lp;
  logic [61:0]        vp;
  logic [8:0]         ip;
  logic [30:0]        pv;
  logic [30:0]        kc;
  logic [RW-1:0]      kf;
  logic [2*RW-1:0]    rpp;
  logic [4:0]         bit_idx;

  assign sub      = {coord_first_i[31], coord_first_i} - {coord_second_i[31], coord_second_i};
  assign sub_neg  = -sub;
  assign diff_in  = sub[32] ? sub_neg[31:0] : sub[31:0];
  assign half_sel = (cmd_i.op == csc_pkg::OP_MUL_HI) ? inv_q[31:16] : inv_q[15:0];
  assign pp       = 48'(diff_q) * 48'(half_sel);
  assign r30      = 31'(prod_q[32 -: RW]) << (csc_pkg::WF - FRAC_BITS);
  assign zp       = 63'(r30) * 63'(csc_pkg::PI_W);
  assign ysh      = y_q >>> cnt_q;
  assign xsh      = x_q >>> cnt_q;
  assign at       = {4'b0000, csc_pkg::atan_w(5'(cnt_q))};
  assign om       = csc_pkg::ONE_W - r30;
  assign om_s     = {1'b0, om};
  assign negy     = -{y_q[33], y_q};
  assign m1p      = 67'(om_s) * 67'(negy);
  assign invpi_s  = {1'b0, csc_pkg::INV_PI_W};
  assign m2p      = 64'(x_q) * 64'(invpi_s);
  assign base     = cmd_i.second ? (csc_pkg::ONE_W - pval_q) : r30;
  assign yexp     = cmd_i.second ? outer_exponent_i : shape_exponent_i;
  assign msq      = 62'(m_q) * 62'(m_q);
  assign logv     = {n_q, 30'b0} - {5'b0, f_q};
  assign lp       = 51'(logv) * 51'(yexp_q);
  assign vp       = 62'(v_q) * 62'(csc_pkg::root_w(5'(cnt_q)));
  assign ip       = u_q[38:30];
  assign bit_idx  = TOP_BIT - 5'(cnt_q);
  assign rpp      = (2*RW)'(rp_q) * (2*RW)'(kf);

  // final power value with the zero exponent and zero base cases
  always_comb begin
    if (exp_zero_q) begin
      pv = csc_pkg::ONE_W;
    end else if (base_zero_q || ip > 9'd30) begin
      pv = '0;
    end else begin
      pv = v_q >> ip[4:0];
    end
  end

  // clamp kernel to [0, 1.0] and cut to output precision
  always_comb begin
    if (k_q[34]) begin
      kc = '0;
    end else if (k_q[33:0] > 34'(csc_pkg::ONE_W)) begin
      kc = csc_pkg::ONE_W;
    end else begin
      kc = k_q[30:0];
    end
    kf = kc[30 -: RW];
  end

  // operation decode
  always_comb begin
    diff_d      = diff_q;
    inv_d       = inv_q;
    last_d      = last_q;
    prod_d      = prod_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    t1_d        = t1_q;
    m_d         = m_q;
    n_d         = n_q;
    f_d         = f_q;
    u_d         = u_q;
    v_d         = v_q;
    pval_d      = pval_q;
    yexp_d      = yexp_q;
    base_zero_d = base_zero_q;
    exp_zero_d  = exp_zero_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    rp_d        = rp_q;
    oos_d       = oos_q;
    out_corr_d  = out_corr_q;
    out_sup_d   = out_sup_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (cmd_i.op)
      csc_pkg::OP_LOAD: begin
        diff_d = diff_in;
        inv_d  = inv_cutoff_i;
        last_d = last_dim_i;
      end
      csc_pkg::OP_MUL_LO: begin
        prod_d = {16'b0, pp};
      end
      csc_pkg::OP_MUL_HI: begin
        prod_d = prod_q + {pp, 16'b0};
      end
      csc_pkg::OP_MARK_OOS: begin
        oos_d = 1'b1;
      end
      csc_pkg::OP_BOH_Z: begin
        z_d   = $signed({1'b0, zp[62:30]}) - $signed({2'b00, csc_pkg::HALF_PI_W});
        x_d   = {4'b0000, csc_pkg::CORDIC_K_W};
        y_d   = '0;
        cnt_d = '0;
      end
      csc_pkg::OP_CORDIC: begin
        if (!z_q[33]) begin
          x_d = x_q - ysh;
          y_d = y_q + xsh;
          z_d = z_q - at;
        end else begin
          x_d = x_q + ysh;
          y_d = y_q - xsh;
          z_d = z_q + at;
        end
        cnt_d = cnt_q + 1'b1;
      end
      csc_pkg::OP_BOH_M1: begin
        t1_d = m1p[63:30];
      end
      csc_pkg::OP_BOH_M2: begin
        k_d = {t1_q[33], t1_q} + {m2p[63], m2p[63:30]};
      end
      csc_pkg::OP_POW_INIT: begin
        m_d         = base;
        n_d         = '0;
        f_d         = '0;
        cnt_d       = '0;
        yexp_d      = yexp;
        base_zero_d = (base == '0);
        exp_zero_d  = (yexp == '0);
      end
      csc_pkg::OP_NORM: begin
        m_d = {m_q[29:0], 1'b0};
        n_d = n_q + 1'b1;
      end
      csc_pkg::OP_LOG: begin
        if (msq[61]) begin
          m_d = msq[61:31];
          f_d[bit_idx] = 1'b1;
        end else begin
          m_d = msq[60:30];
        end
        cnt_d = cnt_q + 1'b1;
      end
      csc_pkg::OP_LOG_MUL: begin
        u_d   = lp[50:12];
        v_d   = csc_pkg::ONE_W;
        cnt_d = '0;
      end
      csc_pkg::OP_EXP: begin
        if (u_q[bit_idx]) begin
          v_d = vp[60:30];
        end
        cnt_d = cnt_q + 1'b1;
      end
      csc_pkg::OP_EXP_FIN: begin
        pval_d = pv;
        k_d    = {4'b0000, pv};
      end
      csc_pkg::OP_ACC: begin
        rp_d = rpp[FRAC_BITS +: RW];
      end
      csc_pkg::OP_EMIT: begin
        out_corr_d  = oos_q ? '0 : rp_q;
        out_sup_d   = !oos_q;
        out_valid_d = 1'b1;
        rp_d        = ONE_OUT;
        oos_d       = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= ONE_OUT;
      oos_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rp_q        <= rp_d;
      oos_q       <= oos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    diff_q      <= diff_d;
    inv_q       <= inv_d;
    last_q      <= last_d;
    prod_q      <= prod_d;
    x_q         <= x_d;
    y_q         <= y_d;
    z_q         <= z_d;
    t1_q        <= t1_d;
    m_q         <= m_d;
    n_q         <= n_d;
    f_q         <= f_d;
    u_q         <= u_d;
    v_q         <= v_d;
    pval_q      <= pval_d;
    yexp_q      <= yexp_d;
    base_zero_q <= base_zero_d;
    exp_zero_q  <= exp_zero_d;
    cnt_q       <= cnt_d;
    k_q         <= k_d;
    out_corr_q  <= out_corr_d;
    out_sup_q   <= out_sup_d;
  end

  // status to the controller
  assign status_o.out_range   = (prod_q[63:33] != '0) || (prod_q[32] && (prod_q[31:0] != '0));
  assign status_o.kernel_sel  = kernel_select_i;
  assign status_o.pow_trivial = base_zero_q || exp_zero_q;
  assign status_o.norm_done   = m_q[30];
  assign status_o.last_step   = (cnt_q == LAST_IT);
  assign status_o.last_dim    = last_q;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign correlation_o = out_corr_q;
  assign in_support_o  = out_sup_q;

endmodule

// File: sv/compact_support_correlation.sv
// Compactly supported correlation kernel, one dimension of a point pair per
// request. Each request gives both coordinates (Q16.16) and the inverse cutoff;
// the block forms r = |a-b| * inv_cutoff, applies the Bohman kernel or the
// power kernel (1 - r^alpha)^nu, and multiplies the clamped value into a
// running product. The request flagged last_dim produces one result: the
// product in Q1.FRAC_BITS and the support flag. One request is in flight at a
// time and all arithmetic runs on a single sequenced datapath. With the Bohman
// kernel a request runs the CORDIC rotation loop; a request whose r exceeds one
// skips the kernel. The power kernel runs the log/exp unit twice; each pass
// first normalises its base, shifting it by 0 to 30 bits, one bit per cycle,
// and a pass with a zero base or exponent skips the log and exp steps. A last_dim
// request also waits while the previous result has not been taken. Registers
// at byte addresses 0, 4 and 8: kernel_select, shape_exponent (alpha, Q4.12),
// outer_exponent (nu, Q4.12).
module compact_support_correlation #(
  parameter int FRAC_BITS  = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // apb configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  coord_first_i,
  input  logic signed [31:0]  coord_second_i,
  input  logic [31:0]         inv_cutoff_i,
  input  logic                last_dim_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [FRAC_BITS:0]  correlation_o,
  output logic                in_support_o
);

  logic        ksel_q, ksel_d;
  logic [15:0] shape_q, shape_d;
  logic [15:0] outer_q, outer_d;
  logic        wr_en;

  csc_pkg::csc_cmd_t    cmd;
  csc_pkg::csc_status_t status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_comb begin
    ksel_d  = ksel_q;
    shape_d = shape_q;
    outer_d = outer_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        csc_pkg::REG_KERNEL_SELECT:  ksel_d  = pwdata[0];
        csc_pkg::REG_SHAPE_EXPONENT: shape_d = pwdata[15:0];
        csc_pkg::REG_OUTER_EXPONENT: outer_d = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksel_q  <= 1'b0;
      shape_q <= 16'd4096;
      outer_q <= 16'd4096;
    end else begin
      ksel_q  <= ksel_d;
      shape_q <= shape_d;
      outer_q <= outer_d;
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      csc_pkg::REG_KERNEL_SELECT:  prdata = {31'b0, ksel_q};
      csc_pkg::REG_SHAPE_EXPONENT: prdata = {16'b0, shape_q};
      csc_pkg::REG_OUTER_EXPONENT: prdata = {16'b0, outer_q};
      default:                     prdata = '0;
    endcase
  end

  csc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  csc_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .ITERATIONS (ITERATIONS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .coord_first_i    (coord_first_i),
    .coord_second_i   (coord_second_i),
    .inv_cutoff_i     (inv_cutoff_i),
    .last_dim_i       (last_dim_i),
    .kernel_select_i  (ksel_q),
    .shape_exponent_i (shape_q),
    .outer_exponent_i (outer_q),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .correlation_o    (correlation_o),
    .in_support_o     (in_support_o)
  );

endmodule

// File: sv/csc_checker.sv
`include "compact_support_correlation_defines.svh"

module csc_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [FRAC_BITS:0] correlation_o,
  input logic               in_support_o
);

  localparam logic [FRAC_BITS:0] CorrMax = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // a stalled result holds
  `CSC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(correlation_o) && $stable(in_support_o))

  // a pair out of support reports zero correlation
  `CSC_ASSERT_IMP(a_zero_outside, out_valid_o && !in_support_o, correlation_o == '0)

  // the product never exceeds one
  `CSC_ASSERT_IMP(a_corr_range, out_valid_o, correlation_o <= CorrMax)

  // one request in flight: busy right after an accept
  `CSC_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind compact_support_correlation csc_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_csc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .correlation_o (correlation_o),
  .in_support_o  (in_support_o)
);
